@@ rtl/cda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date arithmetic - shared package
// Field widths, calendar constants, FSM states and controller/datapath types.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int MAX_YEAR   = 4095;
    localparam int COUNT_BITS = 21;

    localparam int OP_W    = 2;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 21;
    localparam int DIFF_W  = 22;

    // normalised year can sit one above the field range (month 13..15)
    localparam int NYEAR_W = YEAR_W + 1;
    localparam int SER_W   = 24;
    localparam int DOY_W   = 9;

    localparam int MONTHS        = 12;
    localparam int DAYS_PER_YEAR = 365;
    localparam int DIFF_LIMIT    = 2**(DIFF_W - 1) - 1;

    // day serial of 0001-01-01 and of MAX_YEAR-12-31
    localparam int LO_SERIAL = 366;
    localparam int HI_SERIAL = DAYS_PER_YEAR * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
                               - (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400 - 1;

    // x / 100 == (x * RECIP100) >> RECIP100_SH for x below about 91000
    localparam int RECIP100    = 83887;
    localparam int RECIP100_W  = 17;
    localparam int RECIP100_SH = 23;

    // year estimate from a serial, biased upwards so the search only steps down
    localparam int YEAR_RECIP    = 2871;
    localparam int YEAR_RECIP_W  = 12;
    localparam int YEAR_RECIP_SH = 20;
    localparam int YEAR_EST_BIAS = 2;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;

    localparam logic [DOY_W-1:0] CUM_DAYS [MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A1,
        ST_A2,
        ST_B1,
        ST_B2,
        ST_CMP,
        ST_EST,
        ST_Y1,
        ST_Y2,
        ST_MONTH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        YSEL_A,
        YSEL_B,
        YSEL_S
    } ysel_t;

    typedef struct packed {
        logic  load_in;
        ysel_t ysel;
        logic  dby_start;
        logic  store_sa;
        logic  store_sb;
        logic  compare;
        logic  estimate;
        logic  probe;
        logic  month;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic is_diff;
        logic dby_gt_s;
    } sts_t;

    function automatic logic [DOY_W-1:0] days_before_month(
        input logic [MONTH_W-1:0] mi,
        input logic               leap
    );
        logic [DOY_W-1:0] v;
        v = CUM_DAYS[mi];
        if (mi >= MONTH_W'(2) && leap)
        begin
            v = v + 1'b1;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/calendar_date_arithmetic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequence: both dates go to day serials through the days-before-year unit;
// a difference then compares and loads the result; add and subtract estimate
// the year and take k = 2..4 year probes (mostly k = 3) before the month split.
// Throughput: one item at a time; the next input transfer is taken the cycle
// after the result is loaded into the output register, even while it stalls.
// Reset (rst_n, asynchronous): controller to idle, output valid cleared.
// ----------------------------------------------------------------------------
// Calendar date arithmetic - top level
// Gregorian add/subtract days and date difference with compare flags.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic        [cda_pkg::OP_W-1:0]     opcode,
    input  wire logic        [cda_pkg::YEAR_W-1:0]   year_a,
    input  wire logic        [cda_pkg::MONTH_W-1:0]  month_a,
    input  wire logic        [cda_pkg::DAY_W-1:0]    day_a,
    input  wire logic        [cda_pkg::YEAR_W-1:0]   year_b,
    input  wire logic        [cda_pkg::MONTH_W-1:0]  month_b,
    input  wire logic        [cda_pkg::DAY_W-1:0]    day_b,
    input  wire logic        [cda_pkg::COUNT_W-1:0]  day_count,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic             [cda_pkg::YEAR_W-1:0]   result_year,
    output logic             [cda_pkg::MONTH_W-1:0]  result_month,
    output logic             [cda_pkg::DAY_W-1:0]    result_day,
    output logic signed      [cda_pkg::DIFF_W-1:0]   day_difference,
    output logic                                     a_before_b,
    output logic                                     a_equals_b,
    output logic                                     out_of_range
);
    import cda_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cda_datapath u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .year_a         (year_a),
        .month_a        (month_a),
        .day_a          (day_a),
        .year_b         (year_b),
        .month_b        (month_b),
        .day_b          (day_b),
        .day_count      (day_count),
        .result_year    (result_year),
        .result_month   (result_month),
        .result_day     (result_day),
        .day_difference (day_difference),
        .a_before_b     (a_before_b),
        .a_equals_b     (a_equals_b),
        .out_of_range   (out_of_range)
    );

endmodule
`default_nettype wire

@@ rtl/cda_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date arithmetic - controller
// Sequences the serial conversions, compare, year search and month split,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire cda_pkg::sts_t sts,
    output cda_pkg::cmd_t      cmd
);
    import cda_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.ysel       = YSEL_A;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_A1;
                end
            end
            ST_A1:
            begin
                cmd.ysel      = YSEL_A;
                cmd.dby_start = 1'b1;
                state_next    = ST_A2;
            end
            ST_A2:
            begin
                cmd.store_sa = 1'b1;
                state_next   = ST_B1;
            end
            ST_B1:
            begin
                cmd.ysel      = YSEL_B;
                cmd.dby_start = 1'b1;
                state_next    = ST_B2;
            end
            ST_B2:
            begin
                cmd.store_sb = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = sts.is_diff ? ST_DONE : ST_EST;
            end
            ST_EST:
            begin
                cmd.estimate = 1'b1;
                state_next   = ST_Y1;
            end
            ST_Y1:
            begin
                cmd.ysel      = YSEL_S;
                cmd.dby_start = 1'b1;
                state_next    = ST_Y2;
            end
            ST_Y2:
            begin
                // year estimate too high: step down and probe again
                cmd.probe  = 1'b1;
                state_next = sts.dby_gt_s ? ST_Y1 : ST_MONTH;
            end
            ST_MONTH:
            begin
                cmd.month  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/cda_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date arithmetic - datapath
// Day serial conversion via a two-step days-before-year unit, add/subtract
// with clamping, difference with saturation, year search and month split.
// ----------------------------------------------------------------------------
module cda_datapath (
    input  wire logic                                clk,
    input  wire cda_pkg::cmd_t                       cmd,
    output cda_pkg::sts_t                            sts,
    input  wire logic        [cda_pkg::OP_W-1:0]     opcode,
    input  wire logic        [cda_pkg::YEAR_W-1:0]   year_a,
    input  wire logic        [cda_pkg::MONTH_W-1:0]  month_a,
    input  wire logic        [cda_pkg::DAY_W-1:0]    day_a,
    input  wire logic        [cda_pkg::YEAR_W-1:0]   year_b,
    input  wire logic        [cda_pkg::MONTH_W-1:0]  month_b,
    input  wire logic        [cda_pkg::DAY_W-1:0]    day_b,
    input  wire logic        [cda_pkg::COUNT_W-1:0]  day_count,
    output logic             [cda_pkg::YEAR_W-1:0]   result_year,
    output logic             [cda_pkg::MONTH_W-1:0]  result_month,
    output logic             [cda_pkg::DAY_W-1:0]    result_day,
    output logic signed      [cda_pkg::DIFF_W-1:0]   day_difference,
    output logic                                     a_before_b,
    output logic                                     a_equals_b,
    output logic                                     out_of_range
);
    import cda_pkg::*;

    localparam int PW  = NYEAR_W + 1 + RECIP100_W;
    localparam int EW  = SER_W - 1 + YEAR_RECIP_W;
    localparam int YQW = NYEAR_W + 1;

    localparam logic signed [SER_W-1:0] DIFF_MAX = SER_W'(DIFF_LIMIT);
    localparam logic signed [SER_W-1:0] DIFF_MIN = -DIFF_MAX;
    localparam logic signed [SER_W-1:0] S_LO     = SER_W'(LO_SERIAL);
    localparam logic signed [SER_W-1:0] S_HI     = SER_W'(HI_SERIAL);

    // month 0 is December of the year before, 13..15 spill into the next year
    function automatic logic [NYEAR_W+MONTH_W-1:0] normalise(
        input logic [YEAR_W-1:0]  y,
        input logic [MONTH_W-1:0] m
    );
        logic [NYEAR_W-1:0] yy;
        logic [MONTH_W-1:0] mi;
        if (m == '0)
        begin
            if (y == '0)
            begin
                yy = '0;
                mi = '0;
            end
            else
            begin
                yy = {1'b0, y} - 1'b1;
                mi = MONTH_W'(MONTHS - 1);
            end
        end
        else if (m <= MONTH_W'(MONTHS))
        begin
            yy = {1'b0, y};
            mi = m - 1'b1;
        end
        else
        begin
            yy = {1'b0, y} + 1'b1;
            mi = m - MONTH_W'(MONTHS + 1);
        end
        return {yy, mi};
    endfunction

    logic        [OP_W-1:0]    op_reg;
    logic        [NYEAR_W-1:0] ya_reg, yb_reg;
    logic        [MONTH_W-1:0] mia_reg, mib_reg;
    logic        [DAY_W-1:0]   da_reg, db_reg;
    logic        [COUNT_W-1:0] cnt_reg;

    logic        [NYEAR_W-1:0] dy_reg, q4_reg, q100_reg, q400_reg;
    logic signed [SER_W-1:0]   sa_reg, sb_reg, s_reg;
    logic        [NYEAR_W-1:0] ys_reg;
    logic        [DOY_W-1:0]   doy_reg;
    logic                      leap_reg;

    logic        [YEAR_W-1:0]  ry_reg;
    logic        [MONTH_W-1:0] rm_reg;
    logic        [DAY_W-1:0]   rd_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic                      before_reg, equal_reg, oor_reg;

    logic        [YEAR_W-1:0]  out_year_reg;
    logic        [MONTH_W-1:0] out_month_reg;
    logic        [DAY_W-1:0]   out_day_reg;
    logic signed [DIFF_W-1:0]  out_diff_reg;
    logic                      out_before_reg, out_equal_reg, out_oor_reg;

    logic        [NYEAR_W+MONTH_W-1:0] norm_a, norm_b;
    logic        [NYEAR_W-1:0] ysel_y;
    logic        [NYEAR_W:0]   y_p3, y_p99, y_p399;
    logic        [PW-1:0]      p100, p400;
    logic        [SER_W-1:0]   dby;
    logic                      leap;
    logic        [MONTH_W-1:0] mi_sel;
    logic        [DAY_W-1:0]   d_sel;
    logic signed [SER_W-1:0]   ser_d;
    logic signed [SER_W-1:0]   cnt_s, sdiff, s_raw;
    logic                      is_diff;
    logic        [EW-1:0]      est_prod;
    logic                      dby_gt_s;
    logic        [MONTH_W-1:0] mi_found;
    logic        [DOY_W-1:0]   dbm_found;

    assign norm_a  = normalise(year_a, month_a);
    assign norm_b  = normalise(year_b, month_b);
    assign is_diff = (op_reg != OP_ADD) && (op_reg != OP_SUB);

    // ---- days before year, step one: quotients by 4, 100 and 400 (ceilings)
    always_comb
    begin
        case (cmd.ysel)
            YSEL_A:  ysel_y = ya_reg;
            YSEL_B:  ysel_y = yb_reg;
            YSEL_S:  ysel_y = ys_reg;
            default: ysel_y = ya_reg;
        endcase
    end

    assign y_p3   = {1'b0, ysel_y} + YQW'(3);
    assign y_p99  = {1'b0, ysel_y} + YQW'(99);
    assign y_p399 = {1'b0, ysel_y} + YQW'(399);
    assign p100   = PW'(y_p99) * PW'(RECIP100);
    assign p400   = PW'(y_p399 >> 2) * PW'(RECIP100);

    // ---- step two: sum and leap flag from the registered quotients
    assign dby = SER_W'(dy_reg) * SER_W'(DAYS_PER_YEAR) + SER_W'(q4_reg)
                 - SER_W'(q100_reg) + SER_W'(q400_reg);
    // the ceilings are exact only when the year is a multiple
    assign leap = (dy_reg[1:0] == 2'b00)
                  && ((YQW'(q100_reg) * YQW'(100) != {1'b0, dy_reg})
                      || (YQW'(q400_reg) * YQW'(400) == {1'b0, dy_reg}));

    assign mi_sel = cmd.store_sa ? mia_reg : mib_reg;
    assign d_sel  = cmd.store_sa ? da_reg : db_reg;
    assign ser_d  = $signed(dby + SER_W'(days_before_month(mi_sel, leap)) + SER_W'(d_sel))
                    - $signed(SER_W'(1));

    assign cnt_s = $signed(SER_W'(cnt_reg[COUNT_BITS-1:0]));
    assign sdiff = sa_reg - sb_reg;
    assign s_raw = (op_reg == OP_ADD) ? sa_reg + cnt_s : sa_reg - cnt_s;

    assign est_prod = EW'(s_reg[SER_W-2:0]) * EW'(YEAR_RECIP);
    assign dby_gt_s = $signed(dby) > s_reg;

    always_comb
    begin
        mi_found = '0;
        for (int k = 1; k < MONTHS; k++)
        begin
            if (days_before_month(MONTH_W'(k), leap_reg) <= doy_reg)
            begin
                mi_found = MONTH_W'(k);
            end
        end
    end

    assign dbm_found = days_before_month(mi_found, leap_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= opcode;
            ya_reg  <= norm_a[NYEAR_W+MONTH_W-1:MONTH_W];
            mia_reg <= norm_a[MONTH_W-1:0];
            da_reg  <= day_a;
            yb_reg  <= norm_b[NYEAR_W+MONTH_W-1:MONTH_W];
            mib_reg <= norm_b[MONTH_W-1:0];
            db_reg  <= day_b;
            cnt_reg <= day_count;
        end

        if (cmd.dby_start)
        begin
            dy_reg   <= ysel_y;
            q4_reg   <= NYEAR_W'(y_p3 >> 2);
            q100_reg <= NYEAR_W'(p100 >> RECIP100_SH);
            q400_reg <= NYEAR_W'(p400 >> RECIP100_SH);
        end

        if (cmd.store_sa)
        begin
            sa_reg <= ser_d;
        end
        if (cmd.store_sb)
        begin
            sb_reg <= ser_d;
        end

        if (cmd.compare)
        begin
            before_reg <= (sa_reg < sb_reg);
            equal_reg  <= (sa_reg == sb_reg);
            ry_reg     <= '0;
            rm_reg     <= '0;
            rd_reg     <= '0;
            if (is_diff)
            begin
                if (sdiff > DIFF_MAX)
                begin
                    diff_reg <= DIFF_W'(DIFF_MAX);
                    oor_reg  <= 1'b1;
                end
                else if (sdiff < DIFF_MIN)
                begin
                    diff_reg <= DIFF_W'(DIFF_MIN);
                    oor_reg  <= 1'b1;
                end
                else
                begin
                    diff_reg <= DIFF_W'(sdiff);
                    oor_reg  <= 1'b0;
                end
            end
            else
            begin
                diff_reg <= '0;
                if (s_raw < S_LO)
                begin
                    s_reg   <= S_LO;
                    oor_reg <= 1'b1;
                end
                else if (s_raw > S_HI)
                begin
                    s_reg   <= S_HI;
                    oor_reg <= 1'b1;
                end
                else
                begin
                    s_reg   <= s_raw;
                    oor_reg <= 1'b0;
                end
            end
        end

        if (cmd.estimate)
        begin
            ys_reg <= NYEAR_W'(est_prod >> YEAR_RECIP_SH) + NYEAR_W'(YEAR_EST_BIAS);
        end

        if (cmd.probe)
        begin
            if (dby_gt_s)
            begin
                ys_reg <= ys_reg - 1'b1;
            end
            else
            begin
                doy_reg  <= DOY_W'(s_reg - $signed(dby));
                leap_reg <= leap;
            end
        end

        if (cmd.month)
        begin
            ry_reg <= YEAR_W'(ys_reg);
            rm_reg <= mi_found + 1'b1;
            rd_reg <= DAY_W'(doy_reg - dbm_found) + DAY_W'(1);
        end

        if (cmd.out_load)
        begin
            out_year_reg   <= ry_reg;
            out_month_reg  <= rm_reg;
            out_day_reg    <= rd_reg;
            out_diff_reg   <= diff_reg;
            out_before_reg <= before_reg;
            out_equal_reg  <= equal_reg;
            out_oor_reg    <= oor_reg;
        end
    end

    assign sts.is_diff  = is_diff;
    assign sts.dby_gt_s = dby_gt_s;

    assign result_year    = out_year_reg;
    assign result_month   = out_month_reg;
    assign result_day     = out_day_reg;
    assign day_difference = out_diff_reg;
    assign a_before_b     = out_before_reg;
    assign a_equals_b     = out_equal_reg;
    assign out_of_range   = out_oor_reg;

endmodule
`default_nettype wire

@@ rtl/cda_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date arithmetic - port checker
// Watches the top level's result channel; bound to the top level below.
// ----------------------------------------------------------------------------
module cda_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic        [cda_pkg::YEAR_W-1:0]   result_year,
    input wire logic        [cda_pkg::MONTH_W-1:0]  result_month,
    input wire logic        [cda_pkg::DAY_W-1:0]    result_day,
    input wire logic signed [cda_pkg::DIFF_W-1:0]   day_difference,
    input wire logic                                a_before_b,
    input wire logic                                a_equals_b,
    input wire logic                                out_of_range
);
    import cda_pkg::*;

    // a stalled result transfer holds its year, day, difference and range flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_year)
            && $stable(result_day) && $stable(day_difference) && $stable(out_of_range))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(a_before_b && a_equals_b))
        else $error("before and equal both set");

    // difference results carry an all-zero date
    a_diff_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_year == '0 |-> result_month == '0 && result_day == '0)
        else $error("difference result with a date");

    // add/subtract results carry a real date and no difference
    a_date_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_year != '0 |-> day_difference == '0
            && result_month != '0 && result_day != '0)
        else $error("malformed date result");

    a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && a_equals_b |-> day_difference == '0)
        else $error("equal dates with a non-zero difference");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (.*);
`default_nettype wire
